[sv/hrbr_pkg.sv]
// Shared types, constants and command codes of the RBSP bit reader.
package hrbr_pkg;

    // Store depth in bytes and the widths that follow from it
    localparam int MAX_RBSP_BYTES = 4096;
    localparam int ADDR_W         = $clog2(MAX_RBSP_BYTES);
    localparam int CNT_W          = $clog2(MAX_RBSP_BYTES + 1);
    localparam int OFF_W          = CNT_W + 3;

    // Command codes
    localparam logic [2:0] CMD_LOAD  = 3'd0;
    localparam logic [2:0] CMD_BITS  = 3'd1;
    localparam logic [2:0] CMD_UE    = 3'd2;
    localparam logic [2:0] CMD_SE    = 3'd3;
    localparam logic [2:0] CMD_CLEAR = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_END  = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;
    localparam logic [1:0] ST_FULL = 2'd3;

    // Bitstream constants
    localparam logic [7:0] EP_BYTE          = 8'h03;
    localparam logic [1:0] ZERO_RUN_MAX     = 2'd2;
    localparam logic [5:0] BIT_COUNT_MAX    = 6'd32;
    localparam logic [5:0] GOLOMB_ZEROS_MAX = 6'd32;
    localparam logic [3:0] BYTE_BITS        = 4'd8;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] byte_value;
        logic       last_byte;
        logic [5:0] bit_count;
    } t_in_item;

    typedef struct packed {
        logic signed [32:0] value;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CLEAR,
        S_BITS,
        S_PREFIX,
        S_SUFFIX,
        S_FETCH,
        S_FINISH
    } t_state;

    // Port group from the sequencer to the byte store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [7:0]        wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

[sv/hrbr_ram.sv]
// Single-port-write, single-port-read byte store with registered read data.
module hrbr_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/hrbr_core.sv]
// Command sequencer: byte loading with emulation-prevention removal and bit/Exp-Golomb reads.
module hrbr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  hrbr_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output hrbr_pkg::t_mem_req  o_mem,
    input  logic [7:0]          i_mem_rdata,
    output logic                o_res_valid,
    output hrbr_pkg::t_out_item o_res,
    input  logic                i_res_take
);

    localparam int OW = hrbr_pkg::OFF_W;
    localparam int CW = hrbr_pkg::CNT_W;
    localparam int AW = hrbr_pkg::ADDR_W;

    // Leading zeros of a byte, 8 for an all-zero byte
    function automatic logic [3:0] lzc8(input logic [7:0] b);
        logic [3:0] c;
        logic       hit;
        c   = 4'd8;
        hit = 1'b0;
        for (int i = 7; i >= 0; i--) begin
            if (!hit && b[i]) begin
                c   = 4'(7 - i);
                hit = 1'b1;
            end
        end
        return c;
    endfunction

    hrbr_pkg::t_state    r_state, n_state;
    hrbr_pkg::t_in_item  r_item, n_item;
    logic [CW-1:0]       r_byte_count, n_byte_count;
    logic [OW-1:0]       r_off, n_off;
    logic [1:0]          r_zero_run, n_zero_run;
    logic                r_closed, n_closed;
    logic [4:0]          r_zeros, n_zeros;
    logic [5:0]          r_need, n_need;
    logic [31:0]         r_acc, n_acc;
    logic                r_res_valid, n_res_valid;
    hrbr_pkg::t_out_item r_res, n_res;

    logic          w_accept;
    logic [OW-1:0] w_total;
    logic [OW-1:0] w_rem;
    logic          w_at_end;
    logic [2:0]    w_p;
    logic [3:0]    w_avail;
    logic [7:0]    w_avail_byte;
    logic [3:0]    w_lz;
    logic [3:0]    w_za;
    logic [5:0]    w_zsum;
    logic          w_bad_count;
    logic          w_bits_short;
    logic          w_sfx_short;
    logic [3:0]    w_take;
    logic [8:0]    w_mask;
    logic [7:0]    w_bits;
    logic [32:0]   w_code;
    logic [32:0]   w_half;
    logic [32:0]   w_ue;
    logic [32:0]   w_se;

    assign w_accept = i_in_valid && !o_in_stall;

    // Position within the stored data
    assign w_total  = {r_byte_count, 3'b000};
    assign w_rem    = w_total - r_off;
    assign w_at_end = (r_off >= w_total);
    assign w_p      = r_off[2:0];
    assign w_avail  = hrbr_pkg::BYTE_BITS - {1'b0, w_p};

    // Prefix scan: zeros left in the current byte from the read position
    assign w_avail_byte = i_mem_rdata & (8'hFF >> w_p);
    assign w_lz         = lzc8(w_avail_byte);
    assign w_za         = w_lz - {1'b0, w_p};
    assign w_zsum       = {1'b0, r_zeros} + {2'b00, w_za};

    // Range checks
    assign w_bad_count  = (r_item.bit_count == 6'd0)
                       || (r_item.bit_count > hrbr_pkg::BIT_COUNT_MAX);
    assign w_bits_short = (w_rem < OW'(r_item.bit_count));
    assign w_sfx_short  = (({1'b0, r_off} + (OW + 1)'(r_zeros)) > {1'b0, w_total});

    // Field fetch: take up to one byte's worth of bits
    assign w_take = ({2'b00, w_avail} < r_need) ? w_avail : r_need[3:0];
    assign w_mask = 9'((9'd1 << w_take) - 9'd1);
    assign w_bits = (i_mem_rdata >> (w_avail - w_take)) & w_mask[7:0];

    // Code number plus one, then ue and se values
    assign w_code = {1'b0, r_acc} | (33'd1 << r_zeros);
    assign w_half = w_code >> 1;
    assign w_ue   = w_code - 33'd1;
    assign w_se   = w_code[0] ? (33'd0 - w_half) : w_half;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            hrbr_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_in_data.cmd)
                        hrbr_pkg::CMD_LOAD:  n_state = hrbr_pkg::S_LOAD;
                        hrbr_pkg::CMD_BITS:  n_state = hrbr_pkg::S_BITS;
                        hrbr_pkg::CMD_UE:    n_state = hrbr_pkg::S_PREFIX;
                        hrbr_pkg::CMD_SE:    n_state = hrbr_pkg::S_PREFIX;
                        hrbr_pkg::CMD_CLEAR: n_state = hrbr_pkg::S_CLEAR;
                        default:             n_state = hrbr_pkg::S_IDLE;
                    endcase
                end
            end
            hrbr_pkg::S_LOAD:  n_state = hrbr_pkg::S_IDLE;
            hrbr_pkg::S_CLEAR: n_state = hrbr_pkg::S_IDLE;
            hrbr_pkg::S_BITS: begin
                if (w_bad_count || w_bits_short) begin
                    n_state = hrbr_pkg::S_IDLE;
                end else begin
                    n_state = hrbr_pkg::S_FETCH;
                end
            end
            hrbr_pkg::S_PREFIX: begin
                if (w_at_end || (w_zsum >= hrbr_pkg::GOLOMB_ZEROS_MAX)) begin
                    n_state = hrbr_pkg::S_IDLE;
                end else if (w_avail_byte != 8'd0) begin
                    n_state = hrbr_pkg::S_SUFFIX;
                end
            end
            hrbr_pkg::S_SUFFIX: begin
                if (w_sfx_short) begin
                    n_state = hrbr_pkg::S_IDLE;
                end else if (r_zeros == 5'd0) begin
                    n_state = hrbr_pkg::S_FINISH;
                end else begin
                    n_state = hrbr_pkg::S_FETCH;
                end
            end
            hrbr_pkg::S_FETCH: begin
                if (r_need == 6'(w_take)) begin
                    n_state = hrbr_pkg::S_FINISH;
                end
            end
            hrbr_pkg::S_FINISH: n_state = hrbr_pkg::S_IDLE;
            default:            n_state = hrbr_pkg::S_IDLE;
        endcase
    end

    // Datapath, store port and result
    always_comb begin
        n_item       = r_item;
        n_byte_count = r_byte_count;
        n_off        = r_off;
        n_zero_run   = r_zero_run;
        n_closed     = r_closed;
        n_zeros      = r_zeros;
        n_need       = r_need;
        n_acc        = r_acc;
        n_res_valid  = r_res_valid && !i_res_take;
        n_res        = r_res;
        o_mem.we     = 1'b0;
        o_mem.waddr  = r_byte_count[AW-1:0];
        o_mem.wdata  = r_item.byte_value;
        case (r_state)
            hrbr_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_item  = i_in_data;
                    n_zeros = 5'd0;
                    n_acc   = 32'd0;
                end
            end
            hrbr_pkg::S_LOAD: begin
                n_res_valid  = 1'b1;
                n_res.value  = 33'sd0;
                n_res.status = hrbr_pkg::ST_OK;
                if (r_closed) begin
                    n_res.status = hrbr_pkg::ST_FULL;
                end else begin
                    if (r_item.byte_value == hrbr_pkg::EP_BYTE
                            && r_zero_run == hrbr_pkg::ZERO_RUN_MAX) begin
                        // drop the emulation-prevention byte
                        n_zero_run = 2'd0;
                    end else if (r_byte_count >= CW'(hrbr_pkg::MAX_RBSP_BYTES)) begin
                        n_res.status = hrbr_pkg::ST_FULL;
                    end else begin
                        o_mem.we     = 1'b1;
                        n_byte_count = r_byte_count + CW'(1);
                        if (r_item.byte_value == 8'd0) begin
                            if (r_zero_run != hrbr_pkg::ZERO_RUN_MAX) begin
                                n_zero_run = r_zero_run + 2'd1;
                            end
                        end else begin
                            n_zero_run = 2'd0;
                        end
                    end
                    if (r_item.last_byte) begin
                        n_closed = 1'b1;
                    end
                end
            end
            hrbr_pkg::S_CLEAR: begin
                n_byte_count = '0;
                n_off        = '0;
                n_zero_run   = 2'd0;
                n_closed     = 1'b0;
                n_res_valid  = 1'b1;
                n_res.value  = 33'sd0;
                n_res.status = hrbr_pkg::ST_OK;
            end
            hrbr_pkg::S_BITS: begin
                n_need = r_item.bit_count;
                if (w_bad_count) begin
                    n_res_valid  = 1'b1;
                    n_res.value  = 33'sd0;
                    n_res.status = hrbr_pkg::ST_BAD;
                end else if (w_bits_short) begin
                    n_off        = w_total;
                    n_res_valid  = 1'b1;
                    n_res.value  = 33'sd0;
                    n_res.status = hrbr_pkg::ST_END;
                end
            end
            hrbr_pkg::S_PREFIX: begin
                if (w_at_end) begin
                    n_off        = w_total;
                    n_res_valid  = 1'b1;
                    n_res.value  = 33'sd0;
                    n_res.status = hrbr_pkg::ST_END;
                end else if (w_zsum >= hrbr_pkg::GOLOMB_ZEROS_MAX) begin
                    // consume zeros up to the limit, then give up
                    n_off        = r_off + OW'(hrbr_pkg::GOLOMB_ZEROS_MAX - {1'b0, r_zeros});
                    n_res_valid  = 1'b1;
                    n_res.value  = 33'sd0;
                    n_res.status = hrbr_pkg::ST_BAD;
                end else if (w_avail_byte != 8'd0) begin
                    // skip the zeros and the terminating one
                    n_off   = r_off + OW'(w_za) + OW'(1);
                    n_zeros = w_zsum[4:0];
                end else begin
                    n_off   = r_off + OW'(w_za);
                    n_zeros = w_zsum[4:0];
                end
            end
            hrbr_pkg::S_SUFFIX: begin
                n_need = {1'b0, r_zeros};
                if (w_sfx_short) begin
                    n_off        = w_total;
                    n_res_valid  = 1'b1;
                    n_res.value  = 33'sd0;
                    n_res.status = hrbr_pkg::ST_END;
                end
            end
            hrbr_pkg::S_FETCH: begin
                n_acc  = (r_acc << w_take) | 32'(w_bits);
                n_off  = r_off + OW'(w_take);
                n_need = r_need - 6'(w_take);
            end
            hrbr_pkg::S_FINISH: begin
                n_res_valid  = 1'b1;
                n_res.status = hrbr_pkg::ST_OK;
                case (r_item.cmd)
                    hrbr_pkg::CMD_UE: n_res.value = w_ue;
                    hrbr_pkg::CMD_SE: n_res.value = w_se;
                    default:          n_res.value = {1'b0, r_acc};
                endcase
            end
            default: begin
                n_res_valid = r_res_valid && !i_res_take;
            end
        endcase
        // Read the byte under the next offset, so its data is ready next cycle
        o_mem.raddr = n_off[AW+2:3];
    end

    // Handshake outputs
    always_comb begin
        o_in_stall  = (r_state != hrbr_pkg::S_IDLE) || r_res_valid;
        o_res_valid = r_res_valid;
        o_res       = r_res;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= hrbr_pkg::S_IDLE;
            r_byte_count <= '0;
            r_off        <= '0;
            r_zero_run   <= 2'd0;
            r_closed     <= 1'b0;
            r_res_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_byte_count <= n_byte_count;
            r_off        <= n_off;
            r_zero_run   <= n_zero_run;
            r_closed     <= n_closed;
            r_res_valid  <= n_res_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_zeros <= n_zeros;
        r_need  <= n_need;
        r_acc   <= n_acc;
        r_res   <= n_res;
    end

endmodule

[sv/h264_rbsp_bit_reader.sv]
// Top level of the H.264 RBSP bit reader: sequencer, byte store and output register.
//
//  channel | direction | payload               | handshake
//  --------+-----------+-----------------------+---------------------------------
//  in      | to block  | hrbr_pkg::t_in_item   | i_in_valid, o_in_stall
//  out     | from block| hrbr_pkg::t_out_item  | o_out_valid, i_out_stall
//
// Load and clear each pass through one state of their own. A bit read fetches the field
// one byte it touches at a time (1 to 5); ue and se scan the prefix one byte at a time,
// then fetch the suffix one byte at a time. The store port reads one byte a cycle.
// Reset is synchronous and empties the unit; the store needs no clearing pass.
// A stall on the output holds the result in the output register; one more result
// waits in the sequencer before the input stalls.
module h264_rbsp_bit_reader (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  hrbr_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output hrbr_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    hrbr_pkg::t_mem_req  w_mem;
    logic [7:0]          w_rdata;
    logic                w_res_valid;
    hrbr_pkg::t_out_item w_res;
    logic                w_res_take;
    logic                r_out_valid;
    hrbr_pkg::t_out_item r_out;

    hrbr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_mem       (w_mem),
        .i_mem_rdata (w_rdata),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    hrbr_ram #(
        .DEPTH (hrbr_pkg::MAX_RBSP_BYTES),
        .WIDTH (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Move a result into the output register when it is empty or being taken
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Hold the payload until taken
    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[sv/hrbr_checker.sv]
// Port-level checks of the RBSP bit reader and their binding to the top level.
module hrbr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input hrbr_pkg::t_in_item  i_in_data,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input hrbr_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);

    // Reset empties the block and opens the input
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear output valid or input stall");

    // A known command keeps the block busy in the following cycle
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_data.cmd <= hrbr_pkg::CMD_CLEAR)
        |=> o_in_stall)
        else $error("input not stalled after a command was taken");

    // Any non-ok status carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status != hrbr_pkg::ST_OK)
        |-> (o_out_data.value == 33'sd0))
        else $error("error result with nonzero value");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

endmodule

bind h264_rbsp_bit_reader hrbr_checker u_hrbr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);

[sim/tb_h264_rbsp_bit_reader.sv]
// Self-checking testbench for the H.264 RBSP bit reader with Exp-Golomb decoding.
`timescale 1ns / 100ps

module tb_h264_rbsp_bit_reader;

    localparam int STALL_LIMIT_CYCLES = 4000;
    localparam int HOLD_OFF_CYCLES    = 300;
    localparam int TAIL_CYCLES        = 50;

    // Command codes the block does not know
    localparam logic [2:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    hrbr_pkg::t_in_item  i_in_data   = '0;
    logic                o_in_stall;
    logic                o_out_valid;
    hrbr_pkg::t_out_item o_out_data;
    logic                i_out_stall = 1'b0;

    // Shadow state of the reader
    logic [7:0]  rbsp_bytes [0:hrbr_pkg::MAX_RBSP_BYTES-1];
    logic [12:0] rbsp_len        = '0;
    logic [15:0] read_pos        = '0;
    logic [1:0]  zero_bytes_seen = '0;
    logic        unit_closed     = 1'b0;

    hrbr_pkg::t_out_item expected_results [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_trigger   = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    h264_rbsp_bit_reader dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Take the next RBSP bit, MSB first, and advance the read position
    function automatic logic next_rbsp_bit();
        int   idx;
        logic b;
        idx = int'(read_pos) >> 3;
        b = rbsp_bytes[idx][7 - read_pos[2:0]];
        read_pos = read_pos + 16'd1;
        return b;
    endfunction

    // Decode one unsigned Exp-Golomb code number; return its status
    function automatic logic [1:0] decode_exp_golomb(output logic [31:0] code_num);
        int          zeros;
        int          total;
        int          i;
        logic        found;
        logic [31:0] acc;
        zeros = 0;
        found = 1'b0;
        code_num = '0;
        total = int'(rbsp_len) * 8;
        while (!found) begin
            if (int'(read_pos) >= total) begin
                read_pos = 16'(total);
                return hrbr_pkg::ST_END;
            end
            found = next_rbsp_bit();
            if (!found) begin
                zeros++;
                if (zeros >= int'(hrbr_pkg::GOLOMB_ZEROS_MAX))
                    return hrbr_pkg::ST_BAD;
            end
        end
        if (int'(read_pos) + zeros > total) begin
            read_pos = 16'(total);
            return hrbr_pkg::ST_END;
        end
        acc = 32'd1;
        for (i = 0; i < zeros; i++)
            acc = {acc[30:0], next_rbsp_bit()};
        code_num = acc - 32'd1;
        return hrbr_pkg::ST_OK;
    endfunction

    // Apply one accepted item to the shadow state and queue its result
    task automatic predict_reader_result(input hrbr_pkg::t_in_item it);
        hrbr_pkg::t_out_item res;
        logic [31:0]         k;
        logic [32:0]         acc;
        int                  total;
        int                  n;
        int                  i;
        res = '0;
        total = int'(rbsp_len) * 8;
        n = int'(it.bit_count);
        case (it.cmd)
            hrbr_pkg::CMD_LOAD: begin
                if (unit_closed) begin
                    res.status = hrbr_pkg::ST_FULL;
                end else begin
                    if (it.byte_value == hrbr_pkg::EP_BYTE
                            && zero_bytes_seen >= hrbr_pkg::ZERO_RUN_MAX) begin
                        // drop emulation-prevention byte
                        zero_bytes_seen = '0;
                    end else if (int'(rbsp_len) >= hrbr_pkg::MAX_RBSP_BYTES) begin
                        res.status = hrbr_pkg::ST_FULL;
                    end else begin
                        rbsp_bytes[rbsp_len] = it.byte_value;
                        rbsp_len = rbsp_len + 13'd1;
                        if (it.byte_value == 8'h00) begin
                            if (zero_bytes_seen < hrbr_pkg::ZERO_RUN_MAX)
                                zero_bytes_seen = zero_bytes_seen + 2'd1;
                        end else begin
                            zero_bytes_seen = '0;
                        end
                    end
                    if (it.last_byte)
                        unit_closed = 1'b1;
                end
            end
            hrbr_pkg::CMD_BITS: begin
                if (n == 0 || n > int'(hrbr_pkg::BIT_COUNT_MAX)) begin
                    res.status = hrbr_pkg::ST_BAD;
                end else if (int'(read_pos) > total || total - int'(read_pos) < n) begin
                    read_pos = 16'(total);
                    res.status = hrbr_pkg::ST_END;
                end else begin
                    acc = '0;
                    for (i = 0; i < n; i++)
                        acc = {acc[31:0], next_rbsp_bit()};
                    res.value = acc;
                end
            end
            hrbr_pkg::CMD_UE: begin
                res.status = decode_exp_golomb(k);
                if (res.status == hrbr_pkg::ST_OK)
                    res.value = {1'b0, k};
            end
            hrbr_pkg::CMD_SE: begin
                res.status = decode_exp_golomb(k);
                if (res.status == hrbr_pkg::ST_OK) begin
                    if (k[0])
                        res.value = {2'b00, k[31:1]} + 33'sd1;
                    else
                        res.value = -$signed({2'b00, k[31:1]});
                end
            end
            hrbr_pkg::CMD_CLEAR: begin
                rbsp_len = '0;
                read_pos = '0;
                zero_bytes_seen = '0;
                unit_closed = 1'b0;
            end
            default: begin
                // unknown command: no result
                return;
            end
        endcase
        expected_results.insert(expected_results.size(), res);
    endtask

    // ------------------------------------------------------------------
    // Item building and sending
    // ------------------------------------------------------------------

    function automatic hrbr_pkg::t_in_item make_item(input logic [2:0] cmd,
                                                     input logic [7:0] b,
                                                     input logic last,
                                                     input logic [5:0] count);
        hrbr_pkg::t_in_item it;
        it.cmd = cmd;
        it.byte_value = b;
        it.last_byte = last;
        it.bit_count = count;
        return it;
    endfunction

    function automatic hrbr_pkg::t_in_item random_item();
        return make_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                         6'($urandom_range(0, 63)));
    endfunction

    // Offer one item, idle before it at random, hold it until accepted
    task automatic send_item(input hrbr_pkg::t_in_item it);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (o_in_stall);
        predict_reader_result(it);
        if (it.cmd <= hrbr_pkg::CMD_CLEAR)
            items_sent++;
    endtask

    // Send an item, now and then preceded by a random one
    task automatic send_with_noise(input hrbr_pkg::t_in_item it);
        if ($urandom_range(0, 79) == 0)
            send_item(random_item());
        send_item(it);
    endtask

    // Lower valid and hold until every expected result has arrived
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic set_traffic(input int send_pct, input int stall_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Build one NAL unit from random syntax elements or zero-heavy bytes, load it, read it back
    task automatic send_random_unit();
        logic               bit_q [$];
        logic [7:0]         raw_q [$];
        hrbr_pkg::t_in_item read_q [$];
        hrbr_pkg::t_in_item it;
        logic [32:0]        code;
        logic [31:0]        fld;
        logic [7:0]         b;
        logic               closing;
        int                 z;
        int                 n;
        int                 i;
        int                 j;
        int                 zr;
        closing = ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 7) == 0) begin
            // zero-heavy raw bytes to provoke overlong codes and end of data
            repeat ($urandom_range(1, 12))
                raw_q.insert(raw_q.size(),
                             ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom));
            repeat ($urandom_range(1, 6))
                read_q.insert(read_q.size(),
                              make_item(3'($urandom_range(int'(hrbr_pkg::CMD_BITS),
                                                          int'(hrbr_pkg::CMD_SE))),
                                        8'($urandom), 1'($urandom),
                                        6'($urandom_range(1, 32))));
        end else begin
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(0, 2) == 0) begin
                    // fixed-width field
                    n = $urandom_range(1, 32);
                    fld = $urandom;
                    for (i = n - 1; i >= 0; i--)
                        bit_q.insert(bit_q.size(), fld[i]);
                    read_q.insert(read_q.size(),
                                  make_item(hrbr_pkg::CMD_BITS, 8'($urandom), 1'($urandom),
                                            6'(n)));
                end else begin
                    // Exp-Golomb code, mostly short prefixes
                    z = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                    : $urandom_range(0, 4);
                    code = (33'd1 << z) | ({1'b0, 32'($urandom)} & ((33'd1 << z) - 33'd1));
                    repeat (z) bit_q.insert(bit_q.size(), 1'b0);
                    for (i = z; i >= 0; i--)
                        bit_q.insert(bit_q.size(), code[i]);
                    read_q.insert(read_q.size(),
                                  make_item($urandom_range(0, 1) ? hrbr_pkg::CMD_UE
                                                                 : hrbr_pkg::CMD_SE,
                                            8'($urandom), 1'($urandom),
                                            6'($urandom_range(0, 63))));
                end
            end
            // stop bit and alignment
            bit_q.insert(bit_q.size(), 1'b1);
            while (bit_q.size() % 8 != 0)
                bit_q.insert(bit_q.size(), 1'b0);
            for (i = 0; i < bit_q.size(); i += 8) begin
                for (j = 0; j < 8; j++)
                    b[7 - j] = bit_q[i + j];
                raw_q.insert(raw_q.size(), b);
            end
        end

        it = random_item();
        it.cmd = hrbr_pkg::CMD_CLEAR;
        send_item(it);

        // Load with emulation prevention inserted after two zero bytes
        zr = 0;
        for (i = 0; i < raw_q.size(); i++) begin
            b = raw_q[i];
            if (zr >= 2 && b <= hrbr_pkg::EP_BYTE) begin
                send_with_noise(make_item(hrbr_pkg::CMD_LOAD, hrbr_pkg::EP_BYTE, 1'b0,
                                          6'($urandom)));
                zr = 0;
            end
            send_with_noise(make_item(hrbr_pkg::CMD_LOAD, b,
                                      closing && (i == raw_q.size() - 1),
                                      6'($urandom)));
            if (b == 8'h00)
                zr = (zr < 2) ? zr + 1 : 2;
            else
                zr = 0;
        end

        // Read back, now and then with a broken item
        for (i = 0; i < read_q.size(); i++) begin
            it = read_q[i];
            if ($urandom_range(0, 39) == 0)
                it = random_item();
            send_with_noise(it);
        end
        repeat ($urandom_range(0, 2))
            send_item(make_item(3'($urandom_range(int'(hrbr_pkg::CMD_BITS),
                                                  int'(hrbr_pkg::CMD_SE))),
                                8'($urandom), 1'($urandom), 6'($urandom_range(1, 32))));
    endtask

    task automatic run_random_stream(input int item_goal);
        int start;
        start = items_sent;
        while (items_sent - start < item_goal)
            send_random_unit();
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_directed_cases();
        set_traffic(20, 20);
        // emulation prevention, mark on a dropped byte, load after close
        send_item(make_item(hrbr_pkg::CMD_CLEAR, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h00, 1'b0, 6'd63));
        send_item(make_item(hrbr_pkg::CMD_LOAD, hrbr_pkg::EP_BYTE, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, hrbr_pkg::EP_BYTE, 1'b1, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'hFF, 1'b0, 6'd0));
        // overlong code, then a read past the end
        send_item(make_item(hrbr_pkg::CMD_UE, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_BITS, 8'h00, 1'b0, 6'd1));
        // reads before close and bad bit counts
        send_item(make_item(hrbr_pkg::CMD_CLEAR, 8'hFF, 1'b1, 6'd63));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'hFF, 1'b0, 6'd32));
        send_item(make_item(hrbr_pkg::CMD_BITS, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_BITS, 8'h00, 1'b0, 6'd33));
        send_item(make_item(hrbr_pkg::CMD_BITS, 8'hFF, 1'b1, 6'd8));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h4C, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_UE, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_SE, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h07, 1'b1, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_SE, 8'h00, 1'b0, 6'd0));
        // code whose suffix runs past the end of the data
        send_item(make_item(hrbr_pkg::CMD_CLEAR, 8'h00, 1'b0, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_LOAD, 8'h07, 1'b1, 6'd0));
        send_item(make_item(hrbr_pkg::CMD_UE, 8'h00, 1'b0, 6'd0));
        // unknown commands
        send_item(make_item(CMD_UNUSED_LO, 8'hAA, 1'b1, 6'd7));
        send_item(make_item(CMD_UNUSED_HI, 8'h55, 1'b0, 6'd40));
        wait_for_drain();
    endtask

    task automatic test_stream_no_idle();
        set_traffic(0, 0);
        run_random_stream(185);
    endtask

    task automatic test_stream_sender_idle();
        set_traffic(66, 0);
        run_random_stream(185);
    endtask

    task automatic test_stream_receiver_stall();
        set_traffic(0, 66);
        run_random_stream(185);
    endtask

    task automatic test_stream_both_idle();
        set_traffic(37, 37);
        run_random_stream(185);
    endtask

    // Hold the output off for a long stretch while items keep coming
    task automatic test_output_hold_off();
        set_traffic(0, 0);
        hold_trigger++;
        run_random_stream(40);
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // Drive the output stall: a long hold when asked, else random
    always @(posedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        hrbr_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, got value %0d status %0d",
                         $time, o_out_data.value, o_out_data.status);
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.value !== want.value || o_out_data.status !== want.status) begin
                    mismatch_count++;
                    $display("%0t: result mismatch: expected value %0d status %0d, %s %0d %s %0d",
                             $time, want.value, want.status, "got value",
                             o_out_data.value, "status", o_out_data.status);
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_stream_no_idle();
        test_stream_sender_idle();
        test_output_hold_off();
        test_stream_receiver_stall();
        test_stream_both_idle();
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
sv/hrbr_pkg.sv
sv/hrbr_ram.sv
sv/hrbr_core.sv
sv/h264_rbsp_bit_reader.sv
sv/hrbr_checker.sv
sim/tb_h264_rbsp_bit_reader.sv
